@@ hdl/crcsv_pkg.sv @@
// Shared constants and types for the CRC-32 stream verifier.
package crcsv_pkg;

  localparam int unsigned CrcWidth   = 32;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CfgWidth   = 32;
  localparam int unsigned IndexWidth = 1;

  localparam logic [CrcWidth-1:0]   CrcPoly    = 32'hEDB8_8320;
  localparam logic [CrcWidth-1:0]   CrcPreset  = 32'hFFFF_FFFF;
  localparam logic [CountWidth-1:0] CountMax   = 32'hFFFF_FFFF;

  typedef enum logic [IndexWidth-1:0] {
    REG_EXPECTED_SIZE = 1'b0,
    REG_EXPECTED_CRC  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    VERDICT_OK   = 2'd0,
    VERDICT_SIZE = 2'd1,
    VERDICT_CRC  = 2'd2
  } verdict_t;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } command_t;

  // Figures of a closed file handed to the verdict logic.
  typedef struct packed {
    logic [CrcWidth-1:0]   crc_final;
    logic [CountWidth-1:0] byte_count;
    logic [CountWidth-1:0] expected_size;
    logic [CrcWidth-1:0]   expected_crc;
  } check_in_t;

endpackage

@@ hdl/crcsv_byte_update.sv @@
// Byte-wide update of a reflected CRC-32 register.
module crcsv_byte_update (
  input  logic [crcsv_pkg::CrcWidth-1:0]  crc_in,
  input  logic [crcsv_pkg::ByteWidth-1:0] data_byte,
  output logic [crcsv_pkg::CrcWidth-1:0]  crc_out
);

  always_comb begin
    logic [crcsv_pkg::CrcWidth-1:0] c;
    c = crc_in ^ {{(crcsv_pkg::CrcWidth-crcsv_pkg::ByteWidth){1'b0}}, data_byte};
    for (int k = 0; k < crcsv_pkg::ByteWidth; k++) begin
      if (c[0]) begin
        c = crcsv_pkg::CrcPoly ^ (c >> 1);
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

@@ hdl/crcsv_verdict.sv @@
// Verdict decision for a closed file: size check first, then CRC check.
module crcsv_verdict (
  input  crcsv_pkg::check_in_t check,
  output crcsv_pkg::verdict_t  verdict
);

  always_comb begin
    if ((check.expected_size != '0) && (check.byte_count != check.expected_size)) begin
      verdict = crcsv_pkg::VERDICT_SIZE;
    end else if ((check.expected_crc != '0) && (check.crc_final != check.expected_crc)) begin
      verdict = crcsv_pkg::VERDICT_CRC;
    end else begin
      verdict = crcsv_pkg::VERDICT_OK;
    end
  end

endmodule

@@ hdl/crc32_stream_verifier_top.sv @@
// Top level of the CRC-32 stream verifier: input register, running state, result register.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+------------------------------------
//   item     | item_valid / item_stall     | command, data_byte
//   result   | result_valid / result_stall | verdict, crc_value, byte_total
//   config   | cfg_write                   | cfg_index, cfg_data
//
// One item is taken every cycle unless an end item is held; a data byte is registered in the input register
// and then folded into the CRC through a single byte-wide XOR network, and an end item's result is registered.
// An end transaction waits in the input register only while the result register is full
// and stalled; data bytes never wait.
// Reset (rst, synchronous) presets the CRC to all ones, clears the count, the expected
// values and both valid flags.
module crc32_stream_verifier_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                command,
  input  logic [crcsv_pkg::ByteWidth-1:0]     data_byte,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [1:0]                          verdict,
  output logic [crcsv_pkg::CrcWidth-1:0]      crc_value,
  output logic [crcsv_pkg::CountWidth-1:0]    byte_total,
  input  logic                                cfg_write,
  input  logic [crcsv_pkg::IndexWidth-1:0]    cfg_index,
  input  logic [crcsv_pkg::CfgWidth-1:0]      cfg_data
);

  logic                                 stage_valid;
  logic                                 stage_command;
  logic [crcsv_pkg::ByteWidth-1:0]      stage_byte;
  logic [crcsv_pkg::CrcWidth-1:0]       crc_register;
  logic [crcsv_pkg::CrcWidth-1:0]       crc_next;
  logic [crcsv_pkg::CountWidth-1:0]     byte_counter;
  logic [crcsv_pkg::CountWidth-1:0]     expected_size;
  logic [crcsv_pkg::CrcWidth-1:0]       expected_crc;
  logic                                 stage_blocked;
  logic                                 item_accept;
  logic                                 stage_fire;
  crcsv_pkg::check_in_t                 check;
  crcsv_pkg::verdict_t                  verdict_next;

  // An end transaction cannot leave the input register while an earlier result is held.
  assign stage_blocked = stage_valid && (stage_command == crcsv_pkg::CMD_END)
                         && result_valid && result_stall;
  assign item_stall    = stage_blocked;
  assign item_accept   = item_valid && !item_stall;
  assign stage_fire    = stage_valid && !stage_blocked;

  crcsv_byte_update u_byte_update (
    .crc_in    (crc_register),
    .data_byte (stage_byte),
    .crc_out   (crc_next)
  );

  assign check.crc_final     = crc_register ^ crcsv_pkg::CrcPreset;
  assign check.byte_count    = byte_counter;
  assign check.expected_size = expected_size;
  assign check.expected_crc  = expected_crc;

  crcsv_verdict u_verdict (
    .check   (check),
    .verdict (verdict_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_size <= '0;
      expected_crc  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        crcsv_pkg::REG_EXPECTED_SIZE: expected_size <= cfg_data;
        crcsv_pkg::REG_EXPECTED_CRC:  expected_crc  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_accept) begin
      stage_valid <= 1'b1;
    end else if (stage_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      stage_command <= command;
      stage_byte    <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register <= crcsv_pkg::CrcPreset;
      byte_counter <= '0;
    end else if (stage_fire) begin
      if (stage_command == crcsv_pkg::CMD_DATA) begin
        crc_register <= crc_next;
        if (byte_counter != crcsv_pkg::CountMax) begin
          byte_counter <= byte_counter + 1'b1;
        end
      end else begin
        crc_register <= crcsv_pkg::CrcPreset;
        byte_counter <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_fire && (stage_command == crcsv_pkg::CMD_END)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && (stage_command == crcsv_pkg::CMD_END)) begin
      verdict    <= verdict_next;
      crc_value  <= check.crc_final;
      byte_total <= byte_counter;
    end
  end

endmodule

@@ verif/tb_crc32_stream_verifier_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the CRC-32 stream verifier: byte streams in, file verdicts checked.
module tb_crc32_stream_verifier_top;

  typedef struct {
    crcsv_pkg::command_t             cmd;
    logic [crcsv_pkg::ByteWidth-1:0] data;
  } file_item_t;

  typedef struct {
    crcsv_pkg::verdict_t              verdict;
    logic [crcsv_pkg::CrcWidth-1:0]   crc;
    logic [crcsv_pkg::CountWidth-1:0] total;
  } file_report_t;

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             item_valid   = 1'b0;
  logic                             item_stall;
  logic                             command      = crcsv_pkg::CMD_DATA;
  logic [crcsv_pkg::ByteWidth-1:0]  data_byte    = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic [1:0]                       verdict;
  logic [crcsv_pkg::CrcWidth-1:0]   crc_value;
  logic [crcsv_pkg::CountWidth-1:0] byte_total;
  logic                             cfg_write    = 1'b0;
  logic [crcsv_pkg::IndexWidth-1:0] cfg_index    = crcsv_pkg::REG_EXPECTED_SIZE;
  logic [crcsv_pkg::CfgWidth-1:0]   cfg_data     = '0;

  file_item_t                      pending_items[$];
  file_report_t                    reports_due[$];
  logic [crcsv_pkg::ByteWidth-1:0] file_bytes[$];
  int unsigned                     mismatch_count = 0;
  int unsigned                     accepted_count = 0;
  int unsigned                     queued_count   = 0;

  // Running state and limits as the block should hold them.
  logic [crcsv_pkg::CrcWidth-1:0]   running_crc;
  logic [crcsv_pkg::CountWidth-1:0] running_count;
  logic [crcsv_pkg::CfgWidth-1:0]   size_limit;
  logic [crcsv_pkg::CfgWidth-1:0]   crc_limit;

  crc32_stream_verifier_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .verdict      (verdict),
    .crc_value    (crc_value),
    .byte_total   (byte_total),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [crcsv_pkg::CrcWidth-1:0] crc32_fold(
      input logic [crcsv_pkg::CrcWidth-1:0]  acc,
      input logic [crcsv_pkg::ByteWidth-1:0] b);
    logic [crcsv_pkg::CrcWidth-1:0] c;
    c = acc ^ {{(crcsv_pkg::CrcWidth-crcsv_pkg::ByteWidth){1'b0}}, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ crcsv_pkg::CrcPoly) : (c >> 1);
    return c;
  endfunction

  function automatic logic [crcsv_pkg::CrcWidth-1:0] file_crc();
    logic [crcsv_pkg::CrcWidth-1:0] acc;
    acc = crcsv_pkg::CrcPreset;
    foreach (file_bytes[i]) acc = crc32_fold(acc, file_bytes[i]);
    return acc ^ crcsv_pkg::CrcPreset;
  endfunction

  // Both sides pause at random, except over a stretch of transactions in mid-run.
  function automatic bit take_break();
    if (accepted_count >= 500 && accepted_count < 850) return 1'b0;
    return $urandom_range(99) < 36;
  endfunction

  always @(posedge clk) begin : drive_items
    file_item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (pending_items.size() != 0 && !take_break()) begin
        nxt = pending_items.pop_front();
        item_valid <= 1'b1;
        command    <= nxt.cmd;
        data_byte  <= nxt.data;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : predict_and_check
    file_report_t                   due;
    logic [crcsv_pkg::CrcWidth-1:0] closing_crc;
    if (rst) begin
      running_crc   = crcsv_pkg::CrcPreset;
      running_count = '0;
      size_limit    = '0;
      crc_limit     = '0;
      result_stall <= 1'b0;
    end else begin
      // Results are taken before new end items are queued, so a stray result is never masked.
      if (result_valid && !result_stall) begin
        if (reports_due.size() == 0) begin
          mismatch_count++;
          $error("result transaction with no closed file: verdict %0d crc %h total %0d",
                 verdict, crc_value, byte_total);
        end else begin
          due = reports_due.pop_front();
          if (verdict !== due.verdict) begin
            mismatch_count++;
            $error("verdict: expected %0d, actual %0d", due.verdict, verdict);
          end
          if (crc_value !== due.crc) begin
            mismatch_count++;
            $error("crc_value: expected %h, actual %h", due.crc, crc_value);
          end
          if (byte_total !== due.total) begin
            mismatch_count++;
            $error("byte_total: expected %0d, actual %0d", due.total, byte_total);
          end
        end
      end
      if (item_valid && !item_stall) begin
        accepted_count++;
        if (command == crcsv_pkg::CMD_END) begin
          closing_crc = running_crc ^ crcsv_pkg::CrcPreset;
          due.crc     = closing_crc;
          due.total   = running_count;
          if (size_limit != '0 && running_count != size_limit)
            due.verdict = crcsv_pkg::VERDICT_SIZE;
          else if (crc_limit != '0 && closing_crc != crc_limit)
            due.verdict = crcsv_pkg::VERDICT_CRC;
          else
            due.verdict = crcsv_pkg::VERDICT_OK;
          reports_due.push_back(due);
          running_crc   = crcsv_pkg::CrcPreset;
          running_count = '0;
        end else begin
          running_crc = crc32_fold(running_crc, data_byte);
          if (running_count != crcsv_pkg::CountMax) running_count++;
        end
      end
      if (cfg_write) begin
        if (cfg_index == crcsv_pkg::REG_EXPECTED_SIZE) size_limit = cfg_data;
        else if (cfg_index == crcsv_pkg::REG_EXPECTED_CRC) crc_limit = cfg_data;
      end
      result_stall <= take_break();
    end
  end

  task automatic set_limits(input logic [crcsv_pkg::CountWidth-1:0] size_lim,
                            input logic [crcsv_pkg::CrcWidth-1:0]   crc_lim);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= crcsv_pkg::REG_EXPECTED_SIZE;
    cfg_data  <= size_lim;
    @(posedge clk);
    cfg_index <= crcsv_pkg::REG_EXPECTED_CRC;
    cfg_data  <= crc_lim;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_end(input logic [crcsv_pkg::ByteWidth-1:0] ignored_byte);
    pending_items.push_back('{cmd: crcsv_pkg::CMD_END, data: ignored_byte});
    queued_count++;
  endtask

  task automatic send_file(input logic [crcsv_pkg::ByteWidth-1:0] ignored_byte);
    foreach (file_bytes[i])
      pending_items.push_back('{cmd: crcsv_pkg::CMD_DATA, data: file_bytes[i]});
    queued_count += file_bytes.size();
    send_end(ignored_byte);
  endtask

  task automatic build_random_file();
    int unsigned len;
    case ($urandom_range(19))
      0:             len = $urandom_range(300, 65);
      1, 2, 3, 4, 5: len = $urandom_range(64, 17);
      default:       len = $urandom_range(16);
    endcase
    file_bytes.delete();
    repeat (len) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Every batch closes with an end transaction, so the block is empty once its verdict is taken.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || item_valid || reports_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [crcsv_pkg::CrcWidth-1:0]   sum;
    logic [crcsv_pkg::CountWidth-1:0] size_lim;
    logic [crcsv_pkg::CrcWidth-1:0]   crc_lim;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Both checks are off after reset: empty files and the byte extremes.
    send_end(8'hFF);
    file_bytes = {8'h00, 8'hFF};
    send_file(8'h5A);
    send_end(8'h00);
    wait_idle();

    // The standard check string with both limits matching.
    file_bytes = {8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    set_limits(9, 32'hCBF4_3926);
    send_file(8'h00);
    wait_idle();

    // Both limits at their maximum and both wrong: the size check wins.
    file_bytes = {8'hA5};
    set_limits(crcsv_pkg::CountMax, 32'hFFFF_FFFF);
    send_file(8'h7E);
    wait_idle();

    // Right size, CRC off by its top bit.
    file_bytes = {8'h3C};
    set_limits(1, file_crc() ^ 32'h8000_0000);
    send_file(8'h81);
    wait_idle();

    // Size check off, CRC check against an empty file.
    set_limits(0, 32'hFFFF_FFFF);
    send_end(8'h01);
    wait_idle();

    // CRC check off, size wrong.
    file_bytes = {8'h80, 8'h01};
    set_limits(3, 0);
    send_file(8'hFE);
    wait_idle();

    while (queued_count < 1350) begin
      build_random_file();
      sum = file_crc();
      case ($urandom_range(5))
        0:       size_lim = '0;
        1, 2:    size_lim = file_bytes.size();
        3:       size_lim = $urandom_range(1) ? file_bytes.size() + 1 : file_bytes.size() - 1;
        4:       size_lim = crcsv_pkg::CountMax;
        default: size_lim = $urandom;
      endcase
      case ($urandom_range(5))
        0:       crc_lim = '0;
        1, 2:    crc_lim = sum;
        3:       crc_lim = sum ^ (32'd1 << $urandom_range(31));
        4:       crc_lim = 32'hFFFF_FFFF;
        default: crc_lim = $urandom;
      endcase
      set_limits(size_lim, crc_lim);
      send_file(8'($urandom_range(255)));
      // Further files under the same limits, and now and then a bare end transaction.
      repeat ($urandom_range(3)) begin
        build_random_file();
        send_file(8'($urandom_range(255)));
      end
      if ($urandom_range(4) == 0) send_end(8'($urandom_range(255)));
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
